>>> rtl/core/mmu_pkg.sv
// ----------------------------------------------------------------------------
// mmu_pkg
// shared types, command codes and helpers for the matrix multiply unit
// ----------------------------------------------------------------------------
package mmu_pkg;

    localparam int DEF_MAX_DIM     = 8;
    localparam int DEF_VALUE_WIDTH = 16;

    localparam int FIELD_VALUE_W = 16;
    localparam int OUT_VALUE_W   = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 4;

    localparam logic [1:0] CMD_WRITE_A = 2'd0;
    localparam logic [1:0] CMD_WRITE_B = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B     = 2'd2;

    typedef struct packed {
        logic [1:0]                      cmd;
        logic [2:0]                      row_index;
        logic [2:0]                      col_index;
        logic signed [FIELD_VALUE_W-1:0] entry_value;
    } t_req;

    typedef struct packed {
        logic [2:0]                    out_row;
        logic [2:0]                    out_col;
        logic signed [OUT_VALUE_W-1:0] out_value;
        logic                          saturated;
        logic                          last;
    } t_result;

    // per-term control travelling with the operands
    typedef struct packed {
        logic       valid;
        logic       first;
        logic       last_term;
        logic       last;
        logic [2:0] row;
        logic [2:0] col;
    } t_tag;

    // size register to its last index: 0 acts as 1, above max acts as max
    function automatic logic [3:0] eff_last(input logic [3:0] r, input logic [3:0] max_dim);
        logic [3:0] res;
        if (r == 4'd0) begin
            res = 4'd0;
        end else if (r > max_dim) begin
            res = max_dim - 4'd1;
        end else begin
            res = r - 4'd1;
        end
        return res;
    endfunction

endpackage

>>> rtl/core/mmu_store.sv
// ----------------------------------------------------------------------------
// mmu_store
// single-port-write, registered-read entry memory for one matrix
// ----------------------------------------------------------------------------
module mmu_store #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 16
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/mmu_seq.sv
// ----------------------------------------------------------------------------
// mmu_seq
// walks row, column and inner index, one product term per cycle
// ----------------------------------------------------------------------------
module mmu_seq #(
    parameter int MAX_DIM = mmu_pkg::DEF_MAX_DIM,
    parameter int DIM_W   = 3,
    parameter int ADDR_W  = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [DIM_W-1:0]  i_m_last,
    input  logic [DIM_W-1:0]  i_n_last,
    input  logic [DIM_W-1:0]  i_k_last,
    output logic [ADDR_W-1:0] o_a_addr,
    output logic [ADDR_W-1:0] o_b_addr,
    output mmu_pkg::t_tag     o_tag,
    output logic              o_running
);
    import mmu_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_seq_state;

    t_seq_state r_state, n_state;
    logic [DIM_W-1:0] r_i, n_i, r_j, n_j, r_t, n_t;
    logic [DIM_W-1:0] r_m_last, n_m_last, r_n_last, n_n_last, r_k_last, n_k_last;
    logic             w_last_t, w_last_j, w_last_i;

    assign w_last_t = (r_t == r_n_last);
    assign w_last_j = (r_j == r_k_last);
    assign w_last_i = (r_i == r_m_last);

    always_comb begin
        n_state  = r_state;
        n_i      = r_i;
        n_j      = r_j;
        n_t      = r_t;
        n_m_last = r_m_last;
        n_n_last = r_n_last;
        n_k_last = r_k_last;
        case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    n_state  = S_RUN;
                    n_i      = '0;
                    n_j      = '0;
                    n_t      = '0;
                    n_m_last = i_m_last;
                    n_n_last = i_n_last;
                    n_k_last = i_k_last;
                end
            end
            S_RUN: begin
                if (w_last_t) begin
                    n_t = '0;
                    if (w_last_j) begin
                        n_j = '0;
                        if (w_last_i) begin
                            n_state = S_IDLE;
                        end else begin
                            n_i = r_i + 1'b1;
                        end
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end else begin
                    n_t = r_t + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_j      <= n_j;
        r_t      <= n_t;
        r_m_last <= n_m_last;
        r_n_last <= n_n_last;
        r_k_last <= n_k_last;
    end

    assign o_a_addr = ADDR_W'(r_i) * ADDR_W'(MAX_DIM) + ADDR_W'(r_t);
    assign o_b_addr = ADDR_W'(r_t) * ADDR_W'(MAX_DIM) + ADDR_W'(r_j);

    always_comb begin
        o_tag.valid     = (r_state == S_RUN);
        o_tag.first     = (r_t == '0);
        o_tag.last_term = w_last_t;
        o_tag.last      = w_last_t && w_last_j && w_last_i;
        o_tag.row       = 3'(r_i);
        o_tag.col       = 3'(r_j);
    end

    assign o_running = (r_state == S_RUN);

endmodule

>>> rtl/core/mmu_mac.sv
// ----------------------------------------------------------------------------
// mmu_mac
// shared multiplier, accumulator and saturation stage
// ----------------------------------------------------------------------------
module mmu_mac #(
    parameter int ENTRY_W = 16,
    parameter int DIM_W   = 3
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mmu_pkg::t_tag             i_tag,
    input  logic signed [ENTRY_W-1:0] i_a,
    input  logic signed [ENTRY_W-1:0] i_b,
    output mmu_pkg::t_result          o_result,
    output logic                      o_valid,
    output logic                      o_busy
);
    import mmu_pkg::*;

    localparam int PROD_W = 2 * ENTRY_W;
    localparam int ACC_W  = PROD_W + DIM_W;
    localparam int SAT_W  = (ACC_W > OUT_VALUE_W + 1) ? ACC_W : OUT_VALUE_W + 1;

    t_tag                     r_t1, r_t2, r_t3;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [SAT_W-1:0]  w_wide;
    logic                     w_ovf;
    t_result                  r_result;
    logic                     r_valid;

    // tag stages: whole tags and the result valid reset, the rest is payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1    <= '0;
            r_t2    <= '0;
            r_t3    <= '0;
            r_valid <= 1'b0;
        end else begin
            r_t1    <= i_tag;
            r_t2    <= r_t1;
            r_t3    <= r_t2;
            r_valid <= r_t3.valid && r_t3.last_term;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (r_t2.valid) begin
            if (r_t2.first) begin
                r_acc <= ACC_W'(r_prod);
            end else begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
    end

    assign w_wide = SAT_W'(r_acc);
    assign w_ovf  = !((&w_wide[SAT_W-1:OUT_VALUE_W-1]) || !(|w_wide[SAT_W-1:OUT_VALUE_W-1]));

    always_ff @(posedge i_clk) begin
        r_result.out_row   <= r_t3.row;
        r_result.out_col   <= r_t3.col;
        r_result.saturated <= w_ovf;
        r_result.last      <= r_t3.last;
        if (w_ovf) begin
            r_result.out_value <= w_wide[SAT_W-1] ? {1'b1, {(OUT_VALUE_W-1){1'b0}}}
                                                  : {1'b0, {(OUT_VALUE_W-1){1'b1}}};
        end else begin
            r_result.out_value <= w_wide[OUT_VALUE_W-1:0];
        end
    end

    assign o_result = r_result;
    assign o_valid  = r_valid;
    assign o_busy   = r_t1.valid || r_t2.valid || r_t3.valid;

endmodule

>>> rtl/core/matrix_matrix_multiply_unit.sv
// ----------------------------------------------------------------------------
// matrix_matrix_multiply_unit
// C = A x B over signed Q8.8 entries, Q16.16 saturated results
// ----------------------------------------------------------------------------
// a request is taken on a clock edge with start high and busy low
// write A / write B requests store one entry in that same cycle and leave
// busy low, so loads go at one per cycle
// a compute request raises busy and walks m x k x n product terms through
// one shared multiplier, one term per cycle, read from two entry memories
// each result appears on o_result with o_valid high for one cycle, in
// row-major order, the final one with last set
// the first result shows once its terms have passed the read, multiply,
// accumulate and output registers; busy stays high through the term walk
// plus the read, multiply, accumulate and output stages
// busy drops in the cycle the last result is shown
// the receiver cannot stall, results are never held back
// size registers: the user writes them on the config port only while idle,
// unenforced; reset sets all three to 8, clears control, entries undefined
// ----------------------------------------------------------------------------
module matrix_matrix_multiply_unit #(
    parameter int MAX_DIM     = mmu_pkg::DEF_MAX_DIM,
    parameter int VALUE_WIDTH = mmu_pkg::DEF_VALUE_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  mmu_pkg::t_req                     i_req,
    output logic                              busy,
    output mmu_pkg::t_result                  o_result,
    output logic                              o_valid,
    input  logic                              i_cfg_we,
    input  logic [mmu_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mmu_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import mmu_pkg::*;

    localparam int ENTRY_W = (VALUE_WIDTH < FIELD_VALUE_W) ? VALUE_WIDTH : FIELD_VALUE_W;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int DIM_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ADDR_W  = (MAX_DIM > 1) ? $clog2(DEPTH) : 1;

    logic [CFG_DATA_W-1:0] r_rows_a, r_inner_size, r_cols_b;
    logic                  w_accept, w_in_range, w_we_a, w_we_b, w_go;
    logic [ADDR_W-1:0]     w_waddr, w_a_addr, w_b_addr;
    logic [3:0]            w_m_eff, w_n_eff, w_k_eff;
    logic [ENTRY_W-1:0]    w_a_data, w_b_data;
    t_tag                  w_tag;
    logic                  w_running, w_mac_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a     <= 4'd8;
            r_inner_size <= 4'd8;
            r_cols_b     <= 4'd8;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROWS_A:     r_rows_a     <= i_cfg_data;
                REG_INNER_SIZE: r_inner_size <= i_cfg_data;
                REG_COLS_B:     r_cols_b     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign busy       = w_running || w_mac_busy;
    assign w_accept   = start && !busy;
    assign w_in_range = (4'(i_req.row_index) < 4'(MAX_DIM))
                     && (4'(i_req.col_index) < 4'(MAX_DIM));
    assign w_we_a     = w_accept && (i_req.cmd == CMD_WRITE_A) && w_in_range;
    assign w_we_b     = w_accept && (i_req.cmd == CMD_WRITE_B) && w_in_range;
    assign w_go       = w_accept && (i_req.cmd == CMD_COMPUTE);
    assign w_waddr    = ADDR_W'(i_req.row_index[DIM_W-1:0]) * ADDR_W'(MAX_DIM)
                      + ADDR_W'(i_req.col_index[DIM_W-1:0]);

    assign w_m_eff = eff_last(r_rows_a, 4'(MAX_DIM));
    assign w_n_eff = eff_last(r_inner_size, 4'(MAX_DIM));
    assign w_k_eff = eff_last(r_cols_b, 4'(MAX_DIM));

    mmu_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (ENTRY_W)
    ) u_store_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (w_waddr),
        .i_wdata (i_req.entry_value[ENTRY_W-1:0]),
        .i_raddr (w_a_addr),
        .o_rdata (w_a_data)
    );

    mmu_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (ENTRY_W)
    ) u_store_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (w_waddr),
        .i_wdata (i_req.entry_value[ENTRY_W-1:0]),
        .i_raddr (w_b_addr),
        .o_rdata (w_b_data)
    );

    mmu_seq #(
        .MAX_DIM (MAX_DIM),
        .DIM_W   (DIM_W),
        .ADDR_W  (ADDR_W)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (w_go),
        .i_m_last  (w_m_eff[DIM_W-1:0]),
        .i_n_last  (w_n_eff[DIM_W-1:0]),
        .i_k_last  (w_k_eff[DIM_W-1:0]),
        .o_a_addr  (w_a_addr),
        .o_b_addr  (w_b_addr),
        .o_tag     (w_tag),
        .o_running (w_running)
    );

    mmu_mac #(
        .ENTRY_W (ENTRY_W),
        .DIM_W   (DIM_W)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (w_tag),
        .i_a      (w_a_data),
        .i_b      (w_b_data),
        .o_result (o_result),
        .o_valid  (o_valid),
        .o_busy   (w_mac_busy)
    );

    a_go_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go |=> busy)
        else $error("compute request did not raise busy");

    a_write_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req.cmd != CMD_COMPUTE)) |=> !busy)
        else $error("write request left the unit busy");

    a_valid_in_run : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without a running compute");

    a_last_drains : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.last) |-> !busy)
        else $error("last result shown while work remains");

endmodule
